>>> sv/next_combination_lexicographic_top_assert.svh
// Assertion macros for the next-combination block.
// Expects aclk and aresetn in the scope of use; no other dependencies.
`ifndef NEXT_COMBINATION_LEXICOGRAPHIC_TOP_ASSERT_SVH
`define NEXT_COMBINATION_LEXICOGRAPHIC_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define NCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define NCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nclex_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and sequencer state type for the
// next-combination block. No dependencies.
package nclex_pkg;

    localparam int ELEM_W = 11;   // element value width
    localparam int SET_W  = 11;   // set_size register width
    localparam int SUB_W  = 7;    // subset_size register width
    localparam int LIM_W  = 13;   // width of the n-k+pos limit compare
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 2'd1;

    typedef enum logic [4:0] {
        ST_LOAD     = 5'b00001,
        ST_SCAN_RD  = 5'b00010,
        ST_SCAN_CMP = 5'b00100,
        ST_EMIT_RD  = 5'b01000,
        ST_EMIT_VAL = 5'b10000
    } state_t;

endpackage

>>> sv/nclex_store.sv
`timescale 1ns / 1ps
// Combination store: one write port, one registered read port.
// Depends on nclex_pkg for the element width.
module nclex_store #(
    parameter int DEPTH = 64
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [nclex_pkg::ELEM_W-1:0]               wr_data,
    input  logic                                       rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [nclex_pkg::ELEM_W-1:0]               rd_data
);
    import nclex_pkg::*;

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/next_combination_lexicographic_top.sv
`timescale 1ns / 1ps
// Lexicographic successor of a k-combination: load k values, emit k values.
// Steps: k values are loaded (one per item), then a right-to-left scan reads
// and compares each position examined (up to k), then each item is read and
// emitted; scan and emit reads use the store's single registered read port.
// Reset (aresetn, synchronous, active low) clears the sequencer, counters and
// output valid, and sets n = k = 1; the store itself is not cleared.
module next_combination_lexicographic_top #(
    parameter int MAX_K = 64,
    parameter int MAX_N = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [nclex_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nclex_pkg::SET_W-1:0]      cfg_wdata,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [nclex_pkg::ELEM_W-1:0]     s_element,
    // result items
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [nclex_pkg::ELEM_W-1:0]     m_element_res,
    output logic                             m_last
);
    import nclex_pkg::*;

    localparam int ADDR_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CNT_W  = (ADDR_W > SUB_W) ? ADDR_W : SUB_W;

    // configuration registers
    logic [SET_W-1:0] set_size_reg;
    logic [SUB_W-1:0] subset_size_reg;

    // sequencer
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;     // values loaded so far
    logic [CNT_W-1:0] pos_reg, pos_next;     // scan position, 1-based
    logic [CNT_W-1:0] fpos_reg, fpos_next;   // position that gets incremented
    logic             found_reg, found_next;
    logic [CNT_W-1:0] j_reg, j_next;         // emit index, 0-based
    logic [ELEM_W-1:0] prev_reg, prev_next;  // last emitted value

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [ELEM_W-1:0] m_element_reg, m_element_next;
    logic              m_last_reg, m_last_next;

    // effective n and k, clamped to their legal ranges
    logic [SET_W-1:0] n_eff;
    logic [SUB_W-1:0] k_eff;
    logic [CNT_W-1:0] k_cnt;

    always_comb begin
        n_eff = set_size_reg;
        if (set_size_reg == '0) begin
            n_eff = SET_W'(1);
        end else if (int'(set_size_reg) > MAX_N) begin
            n_eff = SET_W'(MAX_N);
        end
        k_eff = subset_size_reg;
        if (subset_size_reg == '0) begin
            k_eff = SUB_W'(1);
        end else if (int'(subset_size_reg) > MAX_K) begin
            k_eff = SUB_W'(MAX_K);
        end
    end

    assign k_cnt = CNT_W'(k_eff);

    // store port
    logic              st_wr_en;
    logic              st_rd_en;
    logic [CNT_W-1:0]  st_rd_idx;
    logic [ELEM_W-1:0] st_rd_data;

    assign s_ready  = (state_reg == ST_LOAD);
    assign st_wr_en = s_valid && s_ready;
    assign st_rd_en = (state_reg == ST_SCAN_RD) || (state_reg == ST_EMIT_RD);
    assign st_rd_idx = (state_reg == ST_SCAN_RD) ? (pos_reg - 1'b1) : j_reg;

    nclex_store #(
        .DEPTH (MAX_K)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (s_element),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_idx[ADDR_W-1:0]),
        .rd_data (st_rd_data)
    );

    // Scan limit n - k + pos; 13-bit modular compare is exact for these ranges
    // and never matches when k exceeds n far enough to go negative.
    logic [LIM_W-1:0] limit;
    assign limit = LIM_W'(n_eff) - LIM_W'(k_eff) + LIM_W'(pos_reg);

    logic             out_free;
    logic [CNT_W-1:0] j_inc;
    logic [ELEM_W-1:0] emit_val;

    assign out_free = !m_valid_reg || m_ready;
    assign j_inc    = j_reg + 1'b1;

    // Successor value at index j: copy before the bumped position, bump it,
    // then count up from there. Wrap case is simply 1..k.
    always_comb begin
        if (!found_reg) begin
            emit_val = ELEM_W'(j_inc);
        end else if (j_inc < fpos_reg) begin
            emit_val = st_rd_data;
        end else if (j_inc == fpos_reg) begin
            emit_val = st_rd_data + 1'b1;
        end else begin
            emit_val = prev_reg + 1'b1;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        fpos_next      = fpos_reg;
        found_next     = found_reg;
        j_next         = j_reg;
        prev_next      = prev_reg;
        m_valid_next   = m_valid_reg;
        m_element_next = m_element_reg;
        m_last_next    = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (st_wr_en) begin
                    if (cnt_reg + 1'b1 == k_cnt) begin
                        cnt_next   = '0;
                        pos_next   = k_cnt;
                        state_next = ST_SCAN_RD;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (limit != LIM_W'(st_rd_data)) begin
                    found_next = 1'b1;
                    fpos_next  = pos_reg;
                    j_next     = '0;
                    state_next = ST_EMIT_RD;
                end else if (pos_reg == CNT_W'(1)) begin
                    // final combination: wrap to 1..k
                    found_next = 1'b0;
                    j_next     = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    pos_next   = pos_reg - 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_VAL;
            end
            ST_EMIT_VAL: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_element_next = emit_val;
                    m_last_next    = (j_inc == k_cnt);
                    prev_next      = emit_val;
                    if (j_inc == k_cnt) begin
                        j_next     = '0;
                        state_next = ST_LOAD;
                    end else begin
                        j_next     = j_inc;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        // any register write restarts loading
        if (cfg_wr_en && (cfg_index == CFG_SET_SIZE || cfg_index == CFG_SUBSET_SIZE)) begin
            cnt_next   = '0;
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            cnt_reg         <= '0;
            pos_reg         <= '0;
            fpos_reg        <= '0;
            found_reg       <= 1'b0;
            j_reg           <= '0;
            m_valid_reg     <= 1'b0;
            set_size_reg    <= SET_W'(1);
            subset_size_reg <= SUB_W'(1);
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            fpos_reg    <= fpos_next;
            found_reg   <= found_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SET_SIZE:    set_size_reg    <= cfg_wdata;
                    CFG_SUBSET_SIZE: subset_size_reg <= cfg_wdata[SUB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        prev_reg      <= prev_next;
        m_element_reg <= m_element_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_element_res = m_element_reg;
    assign m_last        = m_last_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
`include "next_combination_lexicographic_top_assert.svh"

    `NCL_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_reg), "sequencer state not one-hot")
    `NCL_ASSERT_NOW(a_cnt_below_k, state_reg == ST_LOAD, cnt_reg < k_cnt, "load count reached k")
    `NCL_ASSERT_NOW(a_scan_pos_range, state_reg == ST_SCAN_CMP,
                    pos_reg != '0 && pos_reg <= k_cnt, "scan position out of range")
    `NCL_ASSERT_NEXT(a_last_ends_emit,
                     state_reg == ST_EMIT_VAL && out_free && j_inc == k_cnt && !cfg_wr_en,
                     state_reg == ST_LOAD && m_valid_reg && m_last_reg,
                     "last item did not end emission")

endmodule
